// ----- rtl/msdst_pkg.sv -----
// shared types, constants and codes for the mass-sorted score table
// no dependencies
package msdst_pkg;

   localparam int CAPACITY    = 64;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int LEAVES      = 1 << IDX_W;
   localparam int COUNT_W     = $clog2(CAPACITY + 1);
   localparam int SCAN_W      = $clog2(IDX_W + 1);
   localparam int MASS_W      = 24;
   localparam int SCORE_W     = 32;
   localparam int TAG_W       = 16;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 3;
   localparam int RSP_COUNT_W = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_REPLACED  = 3'd1,
      ST_DISCARDED = 3'd2,
      ST_REMOVED   = 3'd3,
      ST_EMPTY     = 3'd4,
      ST_FULL      = 3'd5,
      ST_CLEARED   = 3'd6,
      ST_SPARE     = 3'd7
   } status_type;

   typedef struct packed {
      logic [MASS_W-1:0]         mass;
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          tag;
   } entry_type;

   typedef struct packed {
      logic load_new;
      logic take_left;
      logic take_right;
   } cell_ctl_type;

   typedef struct packed {
      logic mass_lt;
      logic mass_eq;
      logic score_ge;
   } cell_flag_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_EXEC = 3'b100
   } state_type;

endpackage

// ----- rtl/msdst_cell.sv -----
// one table slot: holds an entry, compares it with the incoming word
// depends on msdst_pkg
module msdst_cell (
   input  logic                   clock,
   input  msdst_pkg::cell_ctl_type ctl,
   input  msdst_pkg::entry_type   new_entry,
   input  msdst_pkg::entry_type   left_entry,
   input  msdst_pkg::entry_type   right_entry,
   output msdst_pkg::entry_type   entry_q,
   output msdst_pkg::cell_flag_type flags
);

   msdst_pkg::entry_type entry_ff;
   msdst_pkg::entry_type entry_in;

   always_comb begin
      priority if (ctl.load_new) begin
         entry_in = new_entry;
      end else if (ctl.take_left) begin
         entry_in = left_entry;
      end else if (ctl.take_right) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q        = entry_ff;
   assign flags.mass_lt  = new_entry.mass < entry_ff.mass;
   assign flags.mass_eq  = new_entry.mass == entry_ff.mass;
   assign flags.score_ge = $signed(new_entry.score) >= $signed(entry_ff.score);

endmodule

// ----- rtl/msdst_min_tree.sv -----
// registered tournament tree finding the first held slot of lowest score
// depends on msdst_pkg
module msdst_min_tree (
   input  logic                          clock,
   input  msdst_pkg::entry_type          slots [msdst_pkg::CAPACITY],
   input  logic [msdst_pkg::CAPACITY-1:0] occupied,
   output logic [msdst_pkg::IDX_W-1:0]   low_idx
);

   localparam int LEAVES = msdst_pkg::LEAVES;
   localparam int IDX_W  = msdst_pkg::IDX_W;

   logic signed [msdst_pkg::SCORE_W-1:0] node_score [1:2*LEAVES-1];
   logic [IDX_W-1:0]                     node_idx   [1:2*LEAVES-1];
   logic                                 node_ok    [1:2*LEAVES-1];

   logic signed [msdst_pkg::SCORE_W-1:0] score_ff [1:LEAVES-1];
   logic [IDX_W-1:0]                     idx_ff   [1:LEAVES-1];
   logic                                 ok_ff    [1:LEAVES-1];

   always_comb begin
      for (int n = 1; n < LEAVES; n++) begin
         node_score[n] = score_ff[n];
         node_idx[n]   = idx_ff[n];
         node_ok[n]    = ok_ff[n];
      end
      for (int n = 0; n < LEAVES; n++) begin
         node_idx[LEAVES + n] = IDX_W'(n);
         if (n < msdst_pkg::CAPACITY) begin
            node_score[LEAVES + n] = slots[n].score;
            node_ok[LEAVES + n]    = occupied[n];
         end else begin
            node_score[LEAVES + n] = '0;
            node_ok[LEAVES + n]    = 1'b0;
         end
      end
   end

   // right child wins only when strictly lower, so ties keep table order
   always_ff @(posedge clock) begin
      for (int n = 1; n < LEAVES; n++) begin
         if (node_ok[2*n+1] && (!node_ok[2*n] || node_score[2*n+1] < node_score[2*n])) begin
            score_ff[n] <= node_score[2*n+1];
            idx_ff[n]   <= node_idx[2*n+1];
            ok_ff[n]    <= 1'b1;
         end else begin
            score_ff[n] <= node_score[2*n];
            idx_ff[n]   <= node_idx[2*n];
            ok_ff[n]    <= node_ok[2*n];
         end
      end
   end

   assign low_idx = idx_ff[1];

endmodule

// ----- rtl/mass_sorted_dedup_score_table.sv -----
// top level of the mass-sorted candidate table with lowest-score eviction
// depends on msdst_pkg, msdst_cell, msdst_min_tree

// The table is a row of CAPACITY cells kept in descending mass order; every
// cell compares the incoming word with its own entry at once, and an insert
// shifts the tail one cell toward the end. Insert, clear and the unused
// command go from accept straight to the execute state, which registers
// their result. Remove-lowest first passes through a scan state while the
// registered minimum tree settles, then shifts the tail back.
// One command is worked at a time; a new word is accepted as soon as the
// previous result sits in the output register, and a stalled output holds
// the next command in its final cycle until the register frees up.
module mass_sorted_dedup_score_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // entry_mass[23:0], entry_score[55:24], entry_tag[71:56]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // removed_mass[23:0], removed_score[55:24],
                                    // removed_tag[71:56], entry_count[78:72], zero[79]
   output logic [2:0]  rsp_tuser    // status[2:0]
);

   localparam int CAPACITY = msdst_pkg::CAPACITY;
   localparam int COUNT_W  = msdst_pkg::COUNT_W;
   localparam int IDX_W    = msdst_pkg::IDX_W;
   localparam int SCAN_W   = msdst_pkg::SCAN_W;

   msdst_pkg::state_type  state_ff, state_in;
   logic [SCAN_W-1:0]     scan_ff, scan_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   msdst_pkg::cmd_type    cmd_ff;
   msdst_pkg::entry_type  new_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   msdst_pkg::status_type status_ff, status_in;
   msdst_pkg::entry_type  removed_ff, removed_in;
   logic [COUNT_W-1:0]    rsp_count_ff;

   msdst_pkg::entry_type     cell_q   [CAPACITY];
   msdst_pkg::cell_flag_type cell_flag [CAPACITY];
   msdst_pkg::cell_ctl_type  cell_ctl [CAPACITY];

   logic [CAPACITY-1:0] occupied, gt, gt_prev, match, ge_v;
   logic [IDX_W-1:0]    low_idx;
   logic                found, hit_ge, full, out_free, req_fire, do_exec;

   assign req_tready = state_ff == msdst_pkg::S_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign do_exec    = (state_ff == msdst_pkg::S_EXEC) && out_free;
   assign full       = count_ff == COUNT_W'(CAPACITY);

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      msdst_pkg::entry_type left_w, right_w;
      if (k == 0) begin : g_first
         assign left_w = new_ff;
      end else begin : g_mid
         assign left_w = cell_q[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
         assign right_w = cell_q[k];
      end else begin : g_inner
         assign right_w = cell_q[k+1];
      end
      msdst_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl[k]),
         .new_entry   (new_ff),
         .left_entry  (left_w),
         .right_entry (right_w),
         .entry_q     (cell_q[k]),
         .flags       (cell_flag[k])
      );
   end

   msdst_min_tree u_min_tree (
      .clock    (clock),
      .slots    (cell_q),
      .occupied (occupied),
      .low_idx  (low_idx)
   );

   always_comb begin
      for (int k = 0; k < CAPACITY; k++) begin
         occupied[k] = COUNT_W'(k) < count_ff;
         gt[k]       = occupied[k] && cell_flag[k].mass_lt;
         match[k]    = occupied[k] && cell_flag[k].mass_eq;
         ge_v[k]     = cell_flag[k].score_ge;
      end
      gt_prev = {gt[CAPACITY-2:0], 1'b1};
      found   = |match;
      hit_ge  = |(match & ge_v);
   end

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      removed_in   = removed_ff;
      for (int k = 0; k < CAPACITY; k++) begin
         cell_ctl[k] = '0;
      end

      unique case (state_ff)
         msdst_pkg::S_IDLE: begin
            scan_in = '0;
            if (req_fire) begin
               state_in = (msdst_pkg::cmd_type'(req_tuser) == msdst_pkg::CMD_REMOVE)
                          ? msdst_pkg::S_SCAN : msdst_pkg::S_EXEC;
            end
         end
         msdst_pkg::S_SCAN: begin
            scan_in = scan_ff + SCAN_W'(1);
            if (scan_ff == SCAN_W'(IDX_W - 1)) begin
               state_in = msdst_pkg::S_EXEC;
            end
         end
         msdst_pkg::S_EXEC: begin
            if (do_exec) begin
               state_in     = msdst_pkg::S_IDLE;
               rsp_valid_in = 1'b1;
               removed_in   = '0;
               unique case (cmd_ff)
                  msdst_pkg::CMD_INSERT: begin
                     if (found) begin
                        status_in = hit_ge ? msdst_pkg::ST_REPLACED : msdst_pkg::ST_DISCARDED;
                        for (int k = 0; k < CAPACITY; k++) begin
                           cell_ctl[k].load_new = match[k] && ge_v[k];
                        end
                     end else if (full) begin
                        status_in = msdst_pkg::ST_FULL;
                     end else begin
                        status_in = msdst_pkg::ST_INSERTED;
                        count_in  = count_ff + COUNT_W'(1);
                        for (int k = 0; k < CAPACITY; k++) begin
                           cell_ctl[k].load_new  = !gt[k] && gt_prev[k];
                           cell_ctl[k].take_left = !gt[k] && !gt_prev[k];
                        end
                     end
                  end
                  msdst_pkg::CMD_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = msdst_pkg::ST_EMPTY;
                     end else begin
                        status_in  = msdst_pkg::ST_REMOVED;
                        removed_in = cell_q[low_idx];
                        count_in   = count_ff - COUNT_W'(1);
                        for (int k = 0; k < CAPACITY; k++) begin
                           cell_ctl[k].take_right = IDX_W'(k) >= low_idx;
                        end
                     end
                  end
                  msdst_pkg::CMD_CLEAR: begin
                     status_in = msdst_pkg::ST_CLEARED;
                     count_in  = '0;
                  end
                  default: begin
                     status_in = msdst_pkg::ST_DISCARDED;
                  end
               endcase
            end
         end
         default: begin
            state_in = msdst_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msdst_pkg::S_IDLE;
         scan_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff       <= msdst_pkg::cmd_type'(req_tuser);
         new_ff.mass  <= req_tdata[23:0];
         new_ff.score <= req_tdata[55:24];
         new_ff.tag   <= req_tdata[71:56];
      end
      if (do_exec) begin
         status_ff    <= status_in;
         removed_ff   <= removed_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {1'b0, msdst_pkg::RSP_COUNT_W'(rsp_count_ff), removed_ff.tag,
                        removed_ff.score, removed_ff.mass};

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking bench for the mass-sorted candidate table with lowest-score eviction
// drives directed and random command streams, predicts every response word in-bench
// depends on msdst_pkg and mass_sorted_dedup_score_table
`timescale 1ns / 1ps

module testbench;
   import msdst_pkg::*;

   localparam int PERIOD       = 10;
   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_ITEMS = 1000;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 32;
   localparam int REPORT_MAX   = 200;

   typedef struct {
      cmd_type   op;
      entry_type ent;
   } table_cmd_type;

   typedef struct {
      status_type             status;
      entry_type              gone;
      logic [RSP_COUNT_W-1:0] count;
   } table_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // entry_mass[23:0], entry_score[55:24], entry_tag[71:56]
   logic [1:0]  req_tuser = '0;   // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // removed_mass[23:0], removed_score[55:24],
                                  // removed_tag[71:56], entry_count[78:72], zero[79]
   logic [2:0]  rsp_tuser;        // status[2:0]

   table_cmd_type    cmd_q[$];
   table_result_type outcome_q[$];
   table_cmd_type    on_bus;

   entry_type slots[CAPACITY];
   int        held = 0;
   int        peak_held = 0;
   int        words_sent = 0;
   int        words_total = 0;
   int        live_items = 0;
   int        mismatches = 0;
   int        results_seen = 0;
   int        idle_cycles = 0;
   int        status_tally[8] = '{default: 0};

   mass_sorted_dedup_score_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic table_result_type table_update(table_cmd_type c);
      table_result_type r;
      int pos;
      int low;
      int k;
      r.status = ST_DISCARDED;
      r.gone   = '0;
      case (c.op)
         CMD_INSERT: begin
            pos = 0;
            while (pos < held && c.ent.mass < slots[pos].mass)
               pos++;
            if (pos < held && slots[pos].mass == c.ent.mass) begin
               if ($signed(c.ent.score) < $signed(slots[pos].score)) begin
                  r.status = ST_DISCARDED;
               end else begin
                  slots[pos].score = c.ent.score;
                  slots[pos].tag   = c.ent.tag;
                  r.status = ST_REPLACED;
               end
            end else if (held >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               for (k = held; k > pos; k--)
                  slots[k] = slots[k-1];
               slots[pos] = c.ent;
               held++;
               r.status = ST_INSERTED;
            end
         end
         CMD_REMOVE: begin
            if (held == 0) begin
               r.status = ST_EMPTY;
            end else begin
               low = 0;
               for (k = 1; k < held; k++)
                  if ($signed(slots[k].score) < $signed(slots[low].score))
                     low = k;
               r.gone = slots[low];
               for (k = low; k + 1 < held; k++)
                  slots[k] = slots[k+1];
               held--;
               r.status = ST_REMOVED;
            end
         end
         CMD_CLEAR: begin
            held = 0;
            r.status = ST_CLEARED;
         end
         default: begin
            r.status = ST_DISCARDED;
         end
      endcase
      if (held > peak_held)
         peak_held = held;
      r.count = RSP_COUNT_W'(held);
      return r;
   endfunction

   task automatic queue_cmd(cmd_type op, logic [31:0] mass,
                            logic [31:0] score, logic [31:0] tag);
      table_cmd_type c;
      c.op        = op;
      c.ent.mass  = mass[MASS_W-1:0];
      c.ent.score = score[SCORE_W-1:0];
      c.ent.tag   = tag[TAG_W-1:0];
      cmd_q.push_back(c);
      if (op != CMD_NONE)
         live_items++;
   endtask

   // extremes, small values that tie, or anything
   function automatic logic [SCORE_W-1:0] score_pick();
      int r;
      r = $urandom_range(9);
      if (r == 0)
         return 32'h8000_0000;
      if (r == 1)
         return 32'h7FFF_FFFF;
      if (r < 6)
         return $urandom_range(6) - 3;
      return $urandom();
   endfunction

   function automatic int phase_now();
      if (words_sent * 3 < words_total)
         return 0;
      if (words_sent * 3 < words_total * 2)
         return 1;
      return 2;
   endfunction

   function automatic int send_idle_pct();
      case (phase_now())
         0:       return 34;
         1:       return 64;
         default: return 0;
      endcase
   endfunction

   function automatic int recv_idle_pct();
      case (phase_now())
         0:       return 64;
         1:       return 34;
         default: return 0;
      endcase
   endfunction

   task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, got);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            outcome_q.push_back(table_update(on_bus));
            words_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
               on_bus = cmd_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {on_bus.ent.tag, on_bus.ent.score, on_bus.ent.mass};
               req_tuser  <= on_bus.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      table_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct());
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (outcome_q.size() == 0) begin
               mismatches++;
               $display("%0t ns: unexpected word, expected none, actual status %0h data %0h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = outcome_q.pop_front();
               status_tally[int'(want.status)]++;
               check_field("status", 64'(want.status), 64'(rsp_tuser));
               check_field("removed_mass", 64'(want.gone.mass), 64'(rsp_tdata[23:0]));
               check_field("removed_score", 64'($unsigned(want.gone.score)),
                           64'(rsp_tdata[55:24]));
               check_field("removed_tag", 64'(want.gone.tag), 64'(rsp_tdata[71:56]));
               check_field("entry_count", 64'(want.count), 64'(rsp_tdata[78:72]));
            end
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles, %0d words still expected",
                  $time, idle_cycles, outcome_q.size());
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [MASS_W-1:0] base;
      int seg;
      int len;
      int mode;
      int i;
      int r;
      int slot;

      // directed corner cases
      queue_cmd(CMD_REMOVE, '1, '1, '1);
      queue_cmd(CMD_NONE, 32'h5A5A5A, 32'hA5A5_A5A5, 32'h1234);
      queue_cmd(CMD_CLEAR, '0, '0, '0);
      queue_cmd(CMD_INSERT, 32'hFFFFFF, 32'h7FFF_FFFF, 32'hFFFF);
      queue_cmd(CMD_INSERT, 32'h000000, 32'h8000_0000, 32'h0000);
      queue_cmd(CMD_INSERT, 32'h001000, 32'd5, 32'h1111);
      queue_cmd(CMD_INSERT, 32'h001000, 32'd5, 32'h2222);
      queue_cmd(CMD_INSERT, 32'h001000, 32'd4, 32'h3333);
      queue_cmd(CMD_INSERT, 32'h001000, 32'd6, 32'h4444);
      queue_cmd(CMD_INSERT, 32'h000800, 32'd5, 32'h5555);
      queue_cmd(CMD_INSERT, 32'h002000, 32'd6, 32'h6666);
      queue_cmd(CMD_INSERT, 32'h000000, 32'h8000_0001, 32'hAAAA);
      queue_cmd(CMD_INSERT, 32'hFFFFFF, 32'h7FFF_FFFE, 32'h0001);
      queue_cmd(CMD_REMOVE, '0, '0, '0);
      queue_cmd(CMD_REMOVE, '0, '0, '0);
      queue_cmd(CMD_REMOVE, '0, '0, '0);
      queue_cmd(CMD_REMOVE, '0, '0, '0);
      queue_cmd(CMD_NONE, '1, '1, '1);
      queue_cmd(CMD_CLEAR, '1, '1, '1);
      queue_cmd(CMD_REMOVE, '0, '0, '0);
      queue_cmd(CMD_INSERT, 32'h123456, 32'hFFFF_FFFF, 32'h8001);
      queue_cmd(CMD_REMOVE, '0, '0, '0);

      live_items = 0;
      while (live_items < RANDOM_ITEMS) begin
         seg = $urandom_range(99);
         if (seg < 45) begin
            // mixed traffic on a narrow mass window so duplicates are common
            base = MASS_W'($urandom_range(24'hFFFFF0));
            len  = $urandom_range(30, 10);
            for (i = 0; i < len; i++) begin
               r = $urandom_range(99);
               if (r < 64)
                  queue_cmd(CMD_INSERT,
                            ($urandom_range(7) == 0) ? $urandom() : base + $urandom_range(15),
                            score_pick(), $urandom());
               else if (r < 92)
                  queue_cmd(CMD_REMOVE, $urandom(), $urandom(), $urandom());
               else if (r < 96)
                  queue_cmd(CMD_CLEAR, $urandom(), $urandom(), $urandom());
               else
                  queue_cmd(CMD_NONE, $urandom(), $urandom(), $urandom());
            end
         end else if (seg < 65) begin
            // fill to capacity, then hit the full table with new and held masses
            r = $urandom_range(3);
            if (r == 0)
               base = '0;
            else if (r == 1)
               base = MASS_W'(24'hFFFFFF - 2 * CAPACITY - 1);
            else
               base = MASS_W'($urandom_range(24'hFFFFFF - 2 * CAPACITY - 1));
            mode = $urandom_range(2);
            queue_cmd(CMD_CLEAR, $urandom(), $urandom(), $urandom());
            for (i = 0; i < CAPACITY; i++) begin
               if (mode == 0)
                  slot = i;
               else if (mode == 1)
                  slot = CAPACITY - 1 - i;
               else
                  slot = (i * 37) % CAPACITY;
               queue_cmd(CMD_INSERT, base + 2 * slot, score_pick(), $urandom());
            end
            len = $urandom_range(10, 4);
            for (i = 0; i < len; i++)
               queue_cmd(CMD_INSERT,
                         base + 2 * $urandom_range(CAPACITY - 1) + $urandom_range(1),
                         score_pick(), $urandom());
            len = $urandom_range(CAPACITY + 4, 8);
            for (i = 0; i < len; i++)
               queue_cmd(CMD_REMOVE, $urandom(), $urandom(), $urandom());
         end else if (seg < 80) begin
            len = $urandom_range(40, 4);
            for (i = 0; i < len; i++)
               queue_cmd(CMD_REMOVE, $urandom(), $urandom(), $urandom());
         end else begin
            len = $urandom_range(12, 3);
            for (i = 0; i < len; i++)
               queue_cmd(cmd_type'($urandom_range(3)), $urandom(), $urandom(), $urandom());
         end
      end
      words_total = cmd_q.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (cmd_q.size() != 0 || req_tvalid || outcome_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d commands, %0d response words, table peak %0d of %0d entries",
               words_sent, results_seen, peak_held, CAPACITY);
      $display("ins %0d, repl %0d, disc %0d, rem %0d, empty %0d, full %0d, clr %0d",
               status_tally[ST_INSERTED], status_tally[ST_REPLACED],
               status_tally[ST_DISCARDED], status_tally[ST_REMOVED],
               status_tally[ST_EMPTY], status_tally[ST_FULL], status_tally[ST_CLEARED]);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/msdst_pkg.sv
rtl/msdst_cell.sv
rtl/msdst_min_tree.sv
rtl/mass_sorted_dedup_score_table.sv
tb/sv/testbench.sv
